/* design/neighbor_table_with_aging_assert.svh */
// Assertion macros for the neighbor table.
`ifndef NEIGHBOR_TABLE_WITH_AGING_ASSERT_SVH
`define NEIGHBOR_TABLE_WITH_AGING_ASSERT_SVH
`define NTA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define NTA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

/* design/nta_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package nta_pkg;
	localparam int ENTRIES_DEF = 32;
	localparam logic [10:0] LEN_RST = 11'd64;
	localparam logic [15:0] HOLD_RST = 16'd2000;
	localparam logic [15:0] SWEEP_RST = 16'd500;

	localparam logic [1:0] KIND_STATUS = 2'd0;
	localparam logic [1:0] KIND_PEER = 2'd1;
	localparam logic [1:0] KIND_SUMMARY = 2'd2;
	localparam logic [1:0] KIND_NOT_DUE = 2'd3;

	localparam logic [2:0] ST_REFRESHED = 3'd0;
	localparam logic [2:0] ST_INSERTED = 3'd1;
	localparam logic [2:0] ST_BAD_LEN = 3'd2;
	localparam logic [2:0] ST_OWN = 3'd3;
	localparam logic [2:0] ST_FULL = 3'd4;

	localparam logic [1:0] REG_OWN_MAC = 2'd0;
	localparam logic [1:0] REG_EXP_LEN = 2'd1;
	localparam logic [1:0] REG_HOLD = 2'd2;
	localparam logic [1:0] REG_SWEEP = 2'd3;

	typedef struct packed {
		logic cmd;
		logic [31:0] now;
		logic [47:0] src_mac;
		logic [10:0] frame_len;
		logic [47:0] peer_paired_mac;
		logic [7:0] peer_class;
	} in_word_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] status;
		logic [47:0] peer_mac;
		logic [5:0] paired_count;
		logic [5:0] used_entries;
		logic last;
	} out_word_t;

	typedef struct packed {
		logic [135:0] data;
	} rec_t;

	typedef struct packed {
		logic [47:0] own_mac;
		logic [10:0] expected_length;
		logic [15:0] hold_time;
		logic [15:0] sweep_interval;
	} cfg_t;
endpackage
`default_nettype wire

/* design/nta_regs.sv */
`timescale 1ns / 1ps
`default_nettype none
module nta_regs (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [4:0] paddr,
	input wire logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic pready,
	output nta_pkg::cfg_t cfg
);
	logic [1:0] idx;
	assign idx = paddr[4:3];
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.own_mac <= '0;
			cfg.expected_length <= nta_pkg::LEN_RST;
			cfg.hold_time <= nta_pkg::HOLD_RST;
			cfg.sweep_interval <= nta_pkg::SWEEP_RST;
		end else if (psel && penable && pwrite && paddr[2:0] == 3'd0) begin
			unique case (idx)
				nta_pkg::REG_OWN_MAC: cfg.own_mac <= pwdata[47:0];
				nta_pkg::REG_EXP_LEN: cfg.expected_length <= pwdata[10:0];
				nta_pkg::REG_HOLD: cfg.hold_time <= pwdata[15:0];
				nta_pkg::REG_SWEEP: cfg.sweep_interval <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2:0] == 3'd0) begin
			unique case (idx)
				nta_pkg::REG_OWN_MAC: prdata = {16'd0, cfg.own_mac};
				nta_pkg::REG_EXP_LEN: prdata = {53'd0, cfg.expected_length};
				nta_pkg::REG_HOLD: prdata = {48'd0, cfg.hold_time};
				nta_pkg::REG_SWEEP: prdata = {48'd0, cfg.sweep_interval};
				default: prdata = '0;
			endcase
		end
	end
endmodule
`default_nettype wire

/* design/nta_mem.sv */
`timescale 1ns / 1ps
`default_nettype none
module nta_mem #(
	parameter int ENTRIES = nta_pkg::ENTRIES_DEF,
	localparam int AW = $clog2(ENTRIES)
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [AW-1:0] waddr,
	input wire nta_pkg::rec_t wdata,
	input wire logic [AW-1:0] raddr,
	output nta_pkg::rec_t rdata
);
	nta_pkg::rec_t mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* design/nta_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module nta_ctrl #(
	parameter int ENTRIES = nta_pkg::ENTRIES_DEF,
	localparam int AW = $clog2(ENTRIES),
	localparam int CW = $clog2(ENTRIES + 1)
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire nta_pkg::cfg_t cfg,
	input wire logic in_valid,
	output logic in_stall,
	input wire nta_pkg::in_word_t in_data,
	output logic out_valid,
	input wire logic out_stall,
	output nta_pkg::out_word_t out_data,
	output logic busy
);
	// Record layout: mac, expiry, paired mac, class, with active bits in flops.
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_PAIR = 3'd2;
	localparam logic [2:0] S_EMIT = 3'd3;
	localparam logic [2:0] S_LAST = 3'd4;

	logic [2:0] state_q;
	nta_pkg::in_word_t item_q;
	logic [ENTRIES-1:0] active_q;
	logic [CW-1:0] used_q;
	logic [31:0] next_sweep_q;
	logic [CW-1:0] idx_q;
	logic rd_pend_q;
	logic [CW-1:0] rd_idx_q;
	logic free_found_q;
	logic [AW-1:0] free_q;
	logic [5:0] cnt_q;
	logic out_valid_q;
	nta_pkg::out_word_t out_q;

	logic mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	nta_pkg::rec_t mem_wdata, mem_rdata;
	logic [47:0] r_mac, r_pair;
	logic [31:0] r_exp;
	logic [7:0] r_class;
	logic [31:0] sdiff, ediff;
	logic [AW-1:0] ri;
	logic out_free;

	nta_mem #(.ENTRIES(ENTRIES)) u_mem (
		.clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
		.raddr(mem_raddr), .rdata(mem_rdata)
	);

	assign {r_mac, r_exp, r_pair, r_class} = mem_rdata.data;
	assign ri = rd_idx_q[AW-1:0];
	assign sdiff = item_q.now - next_sweep_q;
	assign ediff = r_exp - item_q.now;
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = state_q != S_IDLE || !out_free;
	assign out_valid = out_valid_q;
	assign out_data = out_q;
	assign busy = state_q != S_IDLE || out_valid_q;
	// The pending entry is read again while it waits, so its record stays put.
	assign mem_raddr = rd_pend_q ? ri : idx_q[AW-1:0];

	always_comb begin
		mem_we = 1'b0;
		mem_waddr = free_q;
		mem_wdata.data = {item_q.src_mac, item_q.now + {16'd0, cfg.hold_time},
			item_q.peer_paired_mac, item_q.peer_class};
		if (state_q == S_SCAN && rd_pend_q && r_mac == item_q.src_mac
				&& !item_q.cmd) begin
			mem_we = 1'b1;
			mem_waddr = ri;
		end else if (state_q == S_SCAN && !rd_pend_q && idx_q >= used_q
				&& !item_q.cmd && (free_found_q || used_q != CW'(ENTRIES))) begin
			mem_we = 1'b1;
			mem_waddr = free_found_q ? free_q : used_q[AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			item_q <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			active_q <= '0;
			used_q <= '0;
			next_sweep_q <= '0;
			idx_q <= '0;
			rd_pend_q <= 1'b0;
			rd_idx_q <= '0;
			free_found_q <= 1'b0;
			free_q <= '0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
			out_q <= '0;
		end else begin
			logic out_valid_nxt;
			out_valid_nxt = out_valid_q && out_stall;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && out_free) begin
						idx_q <= '0;
						rd_pend_q <= 1'b0;
						free_found_q <= 1'b0;
						cnt_q <= '0;
						if (!in_data.cmd && in_data.frame_len != cfg.expected_length) begin
							out_q <= '{nta_pkg::KIND_STATUS, nta_pkg::ST_BAD_LEN, 48'd0,
								6'd0, 6'(used_q), 1'b1};
							out_valid_nxt = 1'b1;
						end else if (!in_data.cmd && in_data.src_mac == cfg.own_mac) begin
							out_q <= '{nta_pkg::KIND_STATUS, nta_pkg::ST_OWN, 48'd0,
								6'd0, 6'(used_q), 1'b1};
							out_valid_nxt = 1'b1;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (item_q.cmd) begin
						if (sdiff == 32'd0 || sdiff[31]) begin
							out_q <= '{nta_pkg::KIND_NOT_DUE, 3'd0, 48'd0, 6'd0,
								6'(used_q), 1'b1};
							out_valid_nxt = 1'b1;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_PAIR;
							next_sweep_q <= item_q.now + {16'd0, cfg.sweep_interval};
							idx_q <= '0;
						end
					end else if (rd_pend_q && r_mac == item_q.src_mac) begin
						active_q[ri] <= 1'b1;
						out_q <= '{nta_pkg::KIND_STATUS, nta_pkg::ST_REFRESHED, 48'd0,
							6'd0, 6'(used_q), 1'b1};
						out_valid_nxt = 1'b1;
						rd_pend_q <= 1'b0;
						state_q <= S_IDLE;
					end else if (rd_pend_q) begin
						if (!active_q[ri] && !free_found_q) begin
							free_found_q <= 1'b1;
							free_q <= ri;
						end
						rd_pend_q <= 1'b0;
					end else if (idx_q < used_q) begin
						rd_pend_q <= 1'b1;
						rd_idx_q <= idx_q;
						idx_q <= idx_q + 1'b1;
					end else begin
						state_q <= S_IDLE;
						out_valid_nxt = 1'b1;
						if (free_found_q) begin
							active_q[free_q] <= 1'b1;
							out_q <= '{nta_pkg::KIND_STATUS, nta_pkg::ST_INSERTED, 48'd0,
								6'd0, 6'(used_q), 1'b1};
						end else if (used_q != CW'(ENTRIES)) begin
							active_q[used_q[AW-1:0]] <= 1'b1;
							used_q <= used_q + 1'b1;
							out_q <= '{nta_pkg::KIND_STATUS, nta_pkg::ST_INSERTED, 48'd0,
								6'd0, 6'(used_q + 1'b1), 1'b1};
						end else begin
							out_q <= '{nta_pkg::KIND_STATUS, nta_pkg::ST_FULL, 48'd0,
								6'd0, 6'(used_q), 1'b1};
						end
					end
				end
				S_PAIR: begin
					// Aging pass: issue reads, retire expired entries as data returns.
					if (rd_pend_q) begin
						if (ediff[31]) begin
							active_q[ri] <= 1'b0;
						end
						rd_pend_q <= 1'b0;
					end else if (idx_q < used_q) begin
						rd_pend_q <= 1'b1;
						rd_idx_q <= idx_q;
						idx_q <= idx_q + 1'b1;
					end else begin
						if (used_q != '0 && !active_q[used_q[AW-1:0] - 1'b1]) begin
							used_q <= used_q - 1'b1;
						end
						idx_q <= '0;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (rd_pend_q) begin
						if (out_free) begin
							rd_pend_q <= 1'b0;
							if (active_q[ri] && r_pair == cfg.own_mac && r_class == 8'd1) begin
								out_q <= '{nta_pkg::KIND_PEER, 3'd0, r_mac, 6'd0,
									6'(used_q), 1'b0};
								out_valid_nxt = 1'b1;
								cnt_q <= cnt_q + 1'b1;
							end
						end
					end else if (idx_q < used_q) begin
						rd_pend_q <= 1'b1;
						rd_idx_q <= idx_q;
						idx_q <= idx_q + 1'b1;
					end else begin
						state_q <= S_LAST;
					end
				end
				S_LAST: begin
					if (out_free) begin
						out_q <= '{nta_pkg::KIND_SUMMARY, 3'd0, 48'd0, cnt_q,
							6'(used_q), 1'b1};
						out_valid_nxt = 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			out_valid_q <= out_valid_nxt;
		end
	end
endmodule
`default_nettype wire

/* design/neighbor_table_with_aging.sv */
// Channel | Direction | Handshake
// in      | input     | in_valid / in_stall, payload in_data
// out     | output    | out_valid / out_stall, payload out_data
// cfg     | input     | APB write and read, 64-bit data, registers at 8*i
// The scan is paced by the single read port of the record memory; each entry is read and checked before the next read.
// Reset clears active bits, used count and sweep time; records need no clearing.
// Output stalls hold the sweep loop until the output register frees.
`timescale 1ns / 1ps
`default_nettype none
`include "neighbor_table_with_aging_assert.svh"
module neighbor_table_with_aging #(
	parameter int ENTRIES = nta_pkg::ENTRIES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire nta_pkg::in_word_t in_data,
	output logic out_valid,
	input wire logic out_stall,
	output nta_pkg::out_word_t out_data,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [4:0] paddr,
	input wire logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic pready
);
	nta_pkg::cfg_t cfg;
	logic busy;

	nta_regs u_regs (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready), .cfg(cfg)
	);

	nta_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .in_valid(in_valid),
		.in_stall(in_stall), .in_data(in_data), .out_valid(out_valid),
		.out_stall(out_stall), .out_data(out_data), .busy(busy)
	);

	`NTA_ASSERT_IMPL(a_busy_stall, clk, arst_n, busy && !out_valid, in_stall,
		"input taken while busy")
	`NTA_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(out_data), "stalled word changed")
	`NTA_ASSERT_IMPL(a_used_range, clk, arst_n, 1'b1,
		out_data.used_entries <= 6'(ENTRIES), "used count out of range")
endmodule
`default_nettype wire
